// ===== rtl/pwm_command_framer_crc8_core_macros.svh =====
// Assertion macros shared by the checker of the PWM command framer.
// No dependencies; include by bare file name. The module that uses them supplies i_clk and i_rst_n.
`ifndef PWM_COMMAND_FRAMER_CRC8_CORE_MACROS_SVH
`define PWM_COMMAND_FRAMER_CRC8_CORE_MACROS_SVH

// Property that is checked only while reset is released.
`define PCF_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property that is checked at every edge, reset included.
`define PCF_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/pcf_pkg.sv =====
// Package of the PWM command framer: item types, frame constants, CRC-8 step.
// No dependencies; used by every module of the block.
package pcf_pkg;

    // Frame layout.
    localparam int unsigned FRAME_LEN = 12;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

    localparam logic [IDX_W-1:0] POS_SYNC0   = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_TYPE    = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_ROBOT   = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_ZERO    = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_LEN     = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_CMD     = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_CHANNEL = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_PWM_LO  = IDX_W'(7);
    localparam logic [IDX_W-1:0] POS_PWM_HI  = IDX_W'(8);
    localparam logic [IDX_W-1:0] POS_CRC     = IDX_W'(9);
    localparam logic [IDX_W-1:0] POS_SYNC1   = IDX_W'(10);
    localparam logic [IDX_W-1:0] POS_END     = IDX_W'(11);

    // Constant frame bytes.
    localparam logic [7:0] BYTE_SYNC = 8'd94;
    localparam logic [7:0] BYTE_TYPE = 8'd2;
    localparam logic [7:0] BYTE_ZERO = 8'd0;
    localparam logic [7:0] BYTE_LEN  = 8'd5;
    localparam logic [7:0] BYTE_CMD  = 8'd3;
    localparam logic [7:0] BYTE_END  = 8'd13;

    // Reflected CRC-8 feedback mask.
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Configuration register map.
    localparam int unsigned      ADDR_W        = 3;
    localparam logic             REG_ROBOT_ID  = 1'b0;
    localparam logic [7:0]       ROBOT_ID_RST  = 8'd1;

    // Input item: one PWM command.
    typedef struct packed {
        logic [7:0]  channel;
        logic [15:0] pwm_value;
    } t_cmd;

    // Result item: one frame byte.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
    } t_frame_out;

    // Folds one data byte into the CRC, least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       fb;
        c = crc;
        d = data;
        for (int b = 0; b < 8; b++) begin
            fb = c[0] ^ d[0];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/pwm_command_framer_crc8_core.sv =====
// Top level of the PWM command framer with reflected CRC-8 checksum.
// Instantiates pcf_regs, pcf_cmd_buf and pcf_serializer; depends on pcf_pkg.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_in_data   (t_cmd)
//   output    out        o_out_valid / i_out_ready  o_out_data  (t_frame_out)
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Each command yields twelve frame bytes, one per cycle while the output is ready.
// The byte serializer sets the rate at which commands are taken.
// A one-entry buffer takes the next command while the current frame is still going out.
// The CRC folds in each delivered byte from robot_id to the PWM high byte and is complete at its frame slot.
// Synchronous reset empties the buffer, stops the serializer and sets robot_id to 1.
// Output stalls hold the frame position; the input side stalls only once the buffer is full.
module pwm_command_framer_crc8_core
    import pcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_cmd              i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_frame_out        o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] robot_id;
    logic       hold_valid;
    t_cmd       hold_cmd;
    logic       take;

    // Configuration registers.
    pcf_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_robot_id (robot_id)
    );

    // Input buffer.
    pcf_cmd_buf u_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_cmd        (i_in_data),
        .o_hold_valid (hold_valid),
        .o_hold_cmd   (hold_cmd),
        .i_take       (take)
    );

    // Frame serializer.
    pcf_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_robot_id   (robot_id),
        .i_hold_valid (hold_valid),
        .i_hold_cmd   (hold_cmd),
        .o_take       (take),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (o_out_data)
    );

endmodule

// ===== rtl/pcf_regs.sv =====
// APB-style configuration port holding the robot identifier register.
// Depends on pcf_pkg for the register map and reset value.
module pcf_regs
    import pcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [7:0]        o_robot_id
);

    logic [7:0] r_robot_id;
    logic [7:0] n_robot_id;
    logic       reg_sel;

    // Registers sit on word boundaries; the upper address bit picks the word.
    assign reg_sel = (paddr[ADDR_W-1] == REG_ROBOT_ID);

    // Write in the access phase; out-of-map writes are dropped.
    always_comb begin
        n_robot_id = r_robot_id;
        if (psel && penable && pwrite && reg_sel) begin
            n_robot_id = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_robot_id <= ROBOT_ID_RST;
        end else begin
            r_robot_id <= n_robot_id;
        end
    end

    assign prdata     = reg_sel ? {24'd0, r_robot_id} : 32'd0;
    assign pready     = 1'b1;
    assign o_robot_id = r_robot_id;

endmodule

// ===== rtl/pcf_cmd_buf.sv =====
// One-entry command buffer between the input channel and the serializer.
// Depends on pcf_pkg for the command item type.
module pcf_cmd_buf
    import pcf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_hold_valid,
    output t_cmd o_hold_cmd,
    input  logic i_take
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;

    // The buffer takes an item only when empty, so ready is a register.
    assign o_ready = !r_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = 1'b0;
        end
        if (i_valid && !r_valid) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && !r_valid) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_hold_valid = r_valid;
    assign o_hold_cmd   = r_cmd;

endmodule

// ===== rtl/pcf_serializer.sv =====
// Serializer: walks the twelve frame bytes, one a cycle while ready, and folds the CRC.
// Depends on pcf_pkg for frame layout, item types and the CRC step.
module pcf_serializer
    import pcf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_robot_id,
    input  logic       i_hold_valid,
    input  t_cmd       i_hold_cmd,
    output logic       o_take,
    output logic       o_valid,
    input  logic       i_ready,
    output t_frame_out o_data
);

    logic             r_busy;
    logic             n_busy;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [7:0]       r_crc;
    logic [7:0]       n_crc;
    t_cmd             r_cur;
    logic             fire;
    logic             at_last;
    logic             in_crc;
    logic [7:0]       cur_byte;

    assign fire    = r_busy && i_ready;
    assign at_last = (r_idx == POS_END);
    assign in_crc  = (r_idx >= POS_ROBOT) && (r_idx <= POS_PWM_HI);
    assign o_take  = i_hold_valid && (!r_busy || (fire && at_last));

    // Byte select by frame position.
    always_comb begin
        case (r_idx)
            POS_SYNC0:   cur_byte = BYTE_SYNC;
            POS_TYPE:    cur_byte = BYTE_TYPE;
            POS_ROBOT:   cur_byte = i_robot_id;
            POS_ZERO:    cur_byte = BYTE_ZERO;
            POS_LEN:     cur_byte = BYTE_LEN;
            POS_CMD:     cur_byte = BYTE_CMD;
            POS_CHANNEL: cur_byte = r_cur.channel;
            POS_PWM_LO:  cur_byte = r_cur.pwm_value[7:0];
            POS_PWM_HI:  cur_byte = r_cur.pwm_value[15:8];
            POS_CRC:     cur_byte = r_crc;
            POS_SYNC1:   cur_byte = BYTE_SYNC;
            POS_END:     cur_byte = BYTE_END;
            default:     cur_byte = BYTE_ZERO;
        endcase
    end

    // Sequencing: load a new command or advance on each delivered byte.
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_crc  = r_crc;
        if (o_take) begin
            n_busy = 1'b1;
            n_idx  = POS_SYNC0;
            n_crc  = 8'd0;
        end else if (fire) begin
            if (at_last) begin
                n_busy = 1'b0;
            end
            n_idx = r_idx + IDX_W'(1);
            if (in_crc) begin
                n_crc = crc8_byte(r_crc, cur_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= POS_SYNC0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        if (o_take) begin
            r_cur <= i_hold_cmd;
        end
    end

    assign o_valid           = r_busy;
    assign o_data.frame_byte = cur_byte;
    assign o_data.last       = at_last;

endmodule

// ===== rtl/pcf_checker.sv =====
// Port-level checker for the PWM command framer, bound to the top level.
// Depends on pcf_pkg and the assertion macros header.
`include "pwm_command_framer_crc8_core_macros.svh"

module pcf_checker
    import pcf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_frame_out o_out_data
);

    logic       out_stall;
    logic       out_last;
    logic [7:0] out_byte;

    // Shorthands for the output channel.
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_last  = o_out_valid && o_out_data.last;
    assign out_byte  = o_out_data.frame_byte;

    // A stalled item stays offered.
    `PCF_ASSERT_RUN(a_out_hold, out_stall |=> o_out_valid, "output item dropped while stalled")

    // A stalled item keeps its payload.
    `PCF_ASSERT_RUN(a_out_stable, out_stall |=> $stable(o_out_data), "stalled payload changed")

    // The flagged byte closes the frame with the end marker.
    `PCF_ASSERT_RUN(a_last_byte, out_last |-> out_byte == BYTE_END, "last byte not end marker")

    // Reset leaves no frame in flight.
    `PCF_ASSERT_ALL(a_reset_idle, !i_rst_n |=> !o_out_valid, "output valid right after reset")

endmodule

bind pwm_command_framer_crc8_core pcf_checker u_pcf_checker (.*);

// ===== sim/pcf_frame_checker.sv =====
// Frame checker for the PWM command framer: predicts each twelve-byte frame and compares it.
// Depends on pcf_pkg for the item types, the frame constants and the register map.
module pcf_frame_checker
    import pcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_cmd              i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_frame_out        i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic              i_pready,
    output int                o_bytes_seen,
    output int                o_fault_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] robot_id_q;
    t_frame_out frame_bytes_due[$];
    int         mismatches;
    int         bytes_seen;

    // Reflected CRC-8 over the checksum span, taken as one bit stream, first byte first.
    function automatic logic [7:0] crc8_of_span(input logic [55:0] span);
        logic [7:0] crc;
        logic       feedback;
        crc = 8'h00;
        for (int i = 0; i < 56; i++) begin
            feedback = crc[0] ^ span[i];
            crc      = crc >> 1;
            if (feedback) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Appends the twelve bytes that one command must produce.
    function automatic void queue_frame(input t_cmd cmd);
        logic [7:0]  frame [FRAME_LEN];
        logic [55:0] span;
        t_frame_out  item;
        span = {cmd.pwm_value[15:8], cmd.pwm_value[7:0], cmd.channel,
                BYTE_CMD, BYTE_LEN, BYTE_ZERO, robot_id_q};
        frame[0]  = BYTE_SYNC;
        frame[1]  = BYTE_TYPE;
        frame[2]  = robot_id_q;
        frame[3]  = BYTE_ZERO;
        frame[4]  = BYTE_LEN;
        frame[5]  = BYTE_CMD;
        frame[6]  = cmd.channel;
        frame[7]  = cmd.pwm_value[7:0];
        frame[8]  = cmd.pwm_value[15:8];
        frame[9]  = crc8_of_span(span);
        frame[10] = BYTE_SYNC;
        frame[11] = BYTE_END;
        for (int k = 0; k < FRAME_LEN; k++) begin
            item.frame_byte = frame[k];
            item.last       = (k == FRAME_LEN - 1);
            frame_bytes_due.push_back(item);
        end
    endfunction

    function automatic void note_mismatch(input string what, input int due, input int got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, due, got);
        mismatches++;
    endfunction

    // Track the register, predict on each accepted command, check each accepted byte.
    always @(posedge i_clk) begin
        t_frame_out due;
        if (!i_rst_n) begin
            robot_id_q = ROBOT_ID_RST;
            frame_bytes_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && (i_paddr >> 2) == ADDR_W'(REG_ROBOT_ID)) begin
                robot_id_q = i_pwdata[7:0];
            end
            if (i_in_valid && i_in_ready) begin
                queue_frame(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                bytes_seen++;
                if (frame_bytes_due.size() == 0) begin
                    note_mismatch("unexpected item, frame_byte", -1, i_out_data.frame_byte);
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (i_out_data.frame_byte !== due.frame_byte) begin
                        note_mismatch("frame_byte", due.frame_byte, i_out_data.frame_byte);
                    end
                    if (i_out_data.last !== due.last) begin
                        note_mismatch("last", due.last, i_out_data.last);
                    end
                end
            end
        end
        o_bytes_seen  <= bytes_seen;
        o_fault_count <= mismatches + frame_bytes_due.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the PWM command framer: clock, reset, stimulus, register writes, verdict.
// Depends on pcf_pkg, pwm_command_framer_crc8_core and pcf_frame_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pcf_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CMDS_PER_PASS = 88;
    // Register index with nothing behind it; writes there must be dropped.
    localparam int unsigned REG_SPARE = 1;

    localparam logic [7:0]  EDGE_CHANNELS [4] = '{8'h00, 8'hFF, 8'h01, 8'h80};
    localparam logic [15:0] EDGE_PWMS [5]     = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00,
                                                  16'h8001};

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_cmd              i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_frame_out        o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    int          bytes_seen;
    int          fault_count;
    int          cycle_count   = 0;
    int          cmds_sent     = 0;
    int          burst_left    = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age   = 0;

    pwm_command_framer_crc8_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pcf_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_data    (o_out_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_bytes_seen  (bytes_seen),
        .o_fault_count (fault_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Give up if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver rotates a stall pattern and picks a new one now and then.
    always @(posedge i_clk) begin
        if (pattern_age == 0) begin
            pattern_age <= $urandom_range(40, 300);
            case ($urandom_range(0, 3))
                0: ready_pattern <= 16'hFFFF;
                1: ready_pattern <= 16'($urandom()) | 16'h0001;
                2: ready_pattern <= 16'h00FF;
                default: ready_pattern <= 16'h8000;
            endcase
        end else begin
            pattern_age   <= pattern_age - 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        i_out_ready <= ready_pattern[0];
    end

    // Corner values show up more often than a uniform draw would give them.
    function automatic t_cmd random_cmd();
        t_cmd cmd;
        case ($urandom_range(0, 7))
            0: cmd.channel = 8'h00;
            1: cmd.channel = 8'hFF;
            default: cmd.channel = 8'($urandom());
        endcase
        case ($urandom_range(0, 7))
            0: cmd.pwm_value = 16'h0000;
            1: cmd.pwm_value = 16'hFFFF;
            default: cmd.pwm_value = 16'($urandom());
        endcase
        return cmd;
    endfunction

    // Presents one command and returns at the edge that accepts it.
    task automatic send_cmd(input t_cmd cmd);
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        cmds_sent++;
    endtask

    // Sends commands in bursts with random gaps, junk on the bus while idle.
    task automatic drive_cmds(input t_cmd cmds[$]);
        int gap;
        foreach (cmds[k]) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    i_in_data  <= random_cmd();
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            send_cmd(cmds[k]);
        end
        i_in_valid <= 1'b0;
    endtask

    // Waits until every byte of every accepted command has been delivered.
    task automatic wait_frames_out();
        while (bytes_seen < FRAME_LEN * cmds_sent) begin
            @(posedge i_clk);
        end
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge after it.
    task automatic write_reg(input int unsigned idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx << 2);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        t_cmd        cmds[$];
        t_cmd        cmd;
        logic [31:0] robot_settings [5];

        // Wide writes check that only the low byte is kept.
        robot_settings = '{32'hFFFF_FF00, 32'h0000_00FF, 32'hA5C3_1280, 32'h0000_0001, 32'h0};
        robot_settings[4] = $urandom();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Edge values of both fields, with robot_id still at its reset value.
        foreach (EDGE_CHANNELS[c]) begin
            foreach (EDGE_PWMS[p]) begin
                cmd.channel   = EDGE_CHANNELS[c];
                cmd.pwm_value = EDGE_PWMS[p];
                cmds.push_back(cmd);
            end
        end
        drive_cmds(cmds);
        wait_frames_out();

        // Random commands under each robot_id setting; a dropped write goes along each time.
        foreach (robot_settings[s]) begin
            write_reg(REG_ROBOT_ID, robot_settings[s]);
            write_reg(REG_SPARE, $urandom());
            cmds.delete();
            repeat (CMDS_PER_PASS) cmds.push_back(random_cmd());
            drive_cmds(cmds);
            wait_frames_out();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== pwm_command_framer_crc8_core.f =====
+incdir+rtl
rtl/pcf_pkg.sv
rtl/pcf_regs.sv
rtl/pcf_cmd_buf.sv
rtl/pcf_serializer.sv
rtl/pwm_command_framer_crc8_core.sv
rtl/pcf_checker.sv
sim/pcf_frame_checker.sv
sim/tb_top.sv
